// ===== rtl/bglyph_pkg.sv =====
// ----------------------------------------------------------------------------
// Block glyph package
// Shared constants, payload structs, configuration view and state codes for
// the block-average lightness to character glyph converter.
// ----------------------------------------------------------------------------
package bglyph_pkg;

    // Sizing limits of the design.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_BLOCK  = 16;
    localparam int MAX_GLYPHS = 24;

    // Field widths fixed by the register map and the item formats.
    localparam int COLOR_W     = 8;
    localparam int WIDTH_REG_W = 11;
    localparam int HEIGHT_W    = 16;
    localparam int BSIZE_W     = 5;
    localparam int GCOUNT_W    = 5;
    localparam int GWORD_W     = 64;
    localparam int GLYPH_W     = 8;
    localparam int GLYPH_WORDS = 3;

    // Derived internal widths.
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int BLK_W   = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int IDX_W   = $clog2(MAX_GLYPHS + 1);
    localparam int AVG_W   = 8;
    localparam int AVG_MAX = 255;

    // Accumulator entry: lightness sum and pixel count per block column.
    localparam int SUM_W    = 16;
    localparam int CNT_W    = 9;
    localparam int ENTRY_W  = SUM_W + CNT_W;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // Block column number by reciprocal multiply: slot = col * recip >> shift.
    localparam int SLOT_SHIFT = COL_W + BLK_W + 1;
    localparam int RECIP_W    = SLOT_SHIFT + 1;

    // Glyph index: scaled / 255 by reciprocal multiply.
    localparam int SCALE_W     = GCOUNT_W + AVG_W;
    localparam int IDX_SHIFT   = 21;
    localparam int IDX_RECIP   = ((1 << IDX_SHIFT) + AVG_MAX - 1) / AVG_MAX;
    localparam int IDX_RECIP_W = 14;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Configuration port.
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_BLOCK_WIDTH  = 3'd2,
        REG_BLOCK_HEIGHT = 3'd3,
        REG_GLYPH_COUNT  = 3'd4,
        REG_GLYPHS_LOW   = 3'd5,
        REG_GLYPHS_MID   = 3'd6,
        REG_GLYPHS_HIGH  = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ACCUM,
        BK_DIVIDE,
        BK_SCALE,
        BK_INDEX,
        BK_SEND
    } t_back_state;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic               row_end;
        logic               image_end;
    } t_glyph_item;

    // Effective configuration after zero and range clamping.
    typedef struct packed {
        logic [WIDTH_REG_W-1:0]                 w;
        logic [HEIGHT_W-1:0]                    h;
        logic [BSIZE_W-1:0]                     bw;
        logic [BSIZE_W-1:0]                     bh;
        logic [GCOUNT_W-1:0]                    len;
        logic [GLYPH_WORDS-1:0][GWORD_W-1:0]    glyphs;
    } t_cfg;

    // One classified pixel handed from the front part to the back part.
    typedef struct packed {
        logic [COL_W-1:0] slot;
        logic [AVG_W-1:0] light;
        logic             emit;
        logic             row_end;
        logic             image_end;
    } t_job;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== rtl/bglyph_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bglyph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/bglyph_div.sv =====
// ----------------------------------------------------------------------------
// Block glyph divider
// Restoring divider, one quotient bit per cycle, for sum / count.
// ----------------------------------------------------------------------------
module bglyph_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bglyph_pkg::t_div_req  i_req,
    output bglyph_pkg::t_div_rsp  o_rsp
);
    import bglyph_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LastStep = DIV_CNT_W'(SUM_W - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]     r_quo;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_div;

    logic [CNT_W:0]       w_trial;
    logic [CNT_W:0]       w_diff;
    logic                 w_ge;
    logic [CNT_W-1:0]     n_rem;

    // One trial subtraction per cycle.
    always_comb begin
        w_trial = {r_rem, r_quo[SUM_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_rem   = w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
    end

    // Step control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LastStep) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Quotient shifts in from the bottom as the dividend shifts out the top.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== rtl/bglyph_cfg.sv =====
// ----------------------------------------------------------------------------
// Block glyph configuration registers
// APB register file with read-back and the clamped view used by the datapath.
// ----------------------------------------------------------------------------
module bglyph_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bglyph_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bglyph_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bglyph_pkg::APB_DATA_W-1:0]  prdata,
    output logic                               pready,
    output bglyph_pkg::t_cfg                   o_cfg
);
    import bglyph_pkg::*;

    logic [WIDTH_REG_W-1:0] r_image_width;
    logic [HEIGHT_W-1:0]    r_image_height;
    logic [BSIZE_W-1:0]     r_block_width;
    logic [BSIZE_W-1:0]     r_block_height;
    logic [GCOUNT_W-1:0]    r_glyph_count;
    logic [GWORD_W-1:0]     r_glyphs_low;
    logic [GWORD_W-1:0]     r_glyphs_mid;
    logic [GWORD_W-1:0]     r_glyphs_high;

    t_reg_idx w_idx;
    logic     w_write;

    assign w_idx   = t_reg_idx'(paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W]);
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_REG_W'(640);
            r_image_height <= HEIGHT_W'(480);
            r_block_width  <= BSIZE_W'(1);
            r_block_height <= BSIZE_W'(1);
            r_glyph_count  <= GCOUNT_W'(10);
            r_glyphs_low   <= '0;
            r_glyphs_mid   <= '0;
            r_glyphs_high  <= '0;
        end else if (w_write) begin
            case (w_idx)
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[HEIGHT_W-1:0];
                REG_BLOCK_WIDTH:  r_block_width  <= pwdata[BSIZE_W-1:0];
                REG_BLOCK_HEIGHT: r_block_height <= pwdata[BSIZE_W-1:0];
                REG_GLYPH_COUNT:  r_glyph_count  <= pwdata[GCOUNT_W-1:0];
                REG_GLYPHS_LOW:   r_glyphs_low   <= pwdata[GWORD_W-1:0];
                REG_GLYPHS_MID:   r_glyphs_mid   <= pwdata[GWORD_W-1:0];
                REG_GLYPHS_HIGH:  r_glyphs_high  <= pwdata[GWORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back of the raw register values.
    always_comb begin
        case (w_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(r_image_height);
            REG_BLOCK_WIDTH:  prdata = APB_DATA_W'(r_block_width);
            REG_BLOCK_HEIGHT: prdata = APB_DATA_W'(r_block_height);
            REG_GLYPH_COUNT:  prdata = APB_DATA_W'(r_glyph_count);
            REG_GLYPHS_LOW:   prdata = APB_DATA_W'(r_glyphs_low);
            REG_GLYPHS_MID:   prdata = APB_DATA_W'(r_glyphs_mid);
            REG_GLYPHS_HIGH:  prdata = APB_DATA_W'(r_glyphs_high);
            default:          prdata = '0;
        endcase
    end

    // Zero acts as one; values above the design limits act as the limit.
    always_comb begin
        if (r_image_width == '0) begin
            o_cfg.w = WIDTH_REG_W'(1);
        end else if (r_image_width > WIDTH_REG_W'(MAX_WIDTH)) begin
            o_cfg.w = WIDTH_REG_W'(MAX_WIDTH);
        end else begin
            o_cfg.w = r_image_width;
        end

        o_cfg.h = (r_image_height == '0) ? HEIGHT_W'(1) : r_image_height;

        if (r_block_width == '0) begin
            o_cfg.bw = BSIZE_W'(1);
        end else if (r_block_width > BSIZE_W'(MAX_BLOCK)) begin
            o_cfg.bw = BSIZE_W'(MAX_BLOCK);
        end else begin
            o_cfg.bw = r_block_width;
        end

        if (r_block_height == '0) begin
            o_cfg.bh = BSIZE_W'(1);
        end else if (r_block_height > BSIZE_W'(MAX_BLOCK)) begin
            o_cfg.bh = BSIZE_W'(MAX_BLOCK);
        end else begin
            o_cfg.bh = r_block_height;
        end

        if (r_glyph_count == '0) begin
            o_cfg.len = GCOUNT_W'(1);
        end else if (r_glyph_count > GCOUNT_W'(MAX_GLYPHS)) begin
            o_cfg.len = GCOUNT_W'(MAX_GLYPHS);
        end else begin
            o_cfg.len = r_glyph_count;
        end

        o_cfg.glyphs = {r_glyphs_high, r_glyphs_mid, r_glyphs_low};
    end

endmodule

// ===== rtl/bglyph_front.sv =====
// ----------------------------------------------------------------------------
// Block glyph front part
// Accepts pixels, computes lightness, tracks the raster position and decides
// which block column each pixel feeds and whether it completes a block.
// ----------------------------------------------------------------------------
module bglyph_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  bglyph_pkg::t_pixel i_in_data,
    output logic               o_in_stall,
    input  bglyph_pkg::t_cfg   i_cfg,
    input  logic               i_fifo_full,
    input  logic               i_clearing,
    output logic               o_push,
    output bglyph_pkg::t_job   o_job
);
    import bglyph_pkg::*;

    logic [COL_W-1:0]    r_col;
    logic [HEIGHT_W-1:0] r_row;
    logic [BLK_W-1:0]    r_cib;
    logic [BLK_W-1:0]    r_rib;

    logic                w_accept;
    logic [COL_W:0]      w_col_inc;
    logic [HEIGHT_W:0]   w_row_inc;
    logic [BLK_W:0]      w_cib_inc;
    logic [BLK_W:0]      w_rib_inc;
    logic                w_last_col;
    logic                w_last_row;
    logic                w_last_cib;
    logic                w_last_rib;
    logic [COLOR_W-1:0]  w_max;
    logic [COLOR_W-1:0]  w_min;
    logic [COLOR_W:0]    w_light_sum;
    logic [BLK_W-1:0]    w_bw_m1;
    logic [RECIP_W-1:0]  w_recip;
    logic [RECIP_W-1:0]  w_recip_tab [MAX_BLOCK];
    logic [COL_W+RECIP_W-1:0] w_slot_prod;

    // Reciprocal table for the block width: ceil(2^SLOT_SHIFT / bw).
    for (genvar gi = 0; gi < MAX_BLOCK; gi++) begin : g_recip
        localparam int Divisor  = gi + 1;
        localparam int RecipVal = ((1 << SLOT_SHIFT) + Divisor - 1) / Divisor;
        assign w_recip_tab[gi] = RECIP_W'(RecipVal);
    end

    assign o_in_stall = i_fifo_full || i_clearing;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_push     = w_accept;

    // Lightness is the midpoint of the largest and smallest component.
    always_comb begin
        w_max = i_in_data.red;
        w_min = i_in_data.red;
        if (i_in_data.green > w_max) w_max = i_in_data.green;
        if (i_in_data.blue > w_max)  w_max = i_in_data.blue;
        if (i_in_data.green < w_min) w_min = i_in_data.green;
        if (i_in_data.blue < w_min)  w_min = i_in_data.blue;
        w_light_sum = {1'b0, w_max} + {1'b0, w_min};
    end

    // Row, column and block boundary decisions.
    always_comb begin
        w_col_inc  = {1'b0, r_col} + 1'b1;
        w_row_inc  = {1'b0, r_row} + 1'b1;
        w_cib_inc  = {1'b0, r_cib} + 1'b1;
        w_rib_inc  = {1'b0, r_rib} + 1'b1;
        w_last_col = (w_col_inc >= (COL_W+1)'(i_cfg.w));
        w_last_row = (w_row_inc >= {1'b0, i_cfg.h});
        w_last_cib = w_last_col || (w_cib_inc >= (BLK_W+1)'(i_cfg.bw));
        w_last_rib = w_last_row || (w_rib_inc >= (BLK_W+1)'(i_cfg.bh));
    end

    // Block column number: column / block width via reciprocal multiply.
    always_comb begin
        w_bw_m1     = BLK_W'(i_cfg.bw - 1'b1);
        w_recip     = w_recip_tab[w_bw_m1];
        w_slot_prod = (COL_W+RECIP_W)'(r_col) * (COL_W+RECIP_W)'(w_recip);
    end

    // Item handed to the queue.
    always_comb begin
        o_job.slot      = w_slot_prod[SLOT_SHIFT +: COL_W];
        o_job.light     = w_light_sum[COLOR_W:1];
        o_job.emit      = w_last_cib && w_last_rib;
        o_job.row_end   = w_last_col;
        o_job.image_end = w_last_col && w_last_row;
    end

    // Raster position update on each accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_cib <= '0;
            r_rib <= '0;
        end else if (w_accept) begin
            if (w_last_col) begin
                r_col <= '0;
                r_cib <= '0;
                if (w_last_row) begin
                    r_row <= '0;
                    r_rib <= '0;
                end else begin
                    r_row <= w_row_inc[HEIGHT_W-1:0];
                    r_rib <= w_last_rib ? '0 : w_rib_inc[BLK_W-1:0];
                end
            end else begin
                r_col <= w_col_inc[COL_W-1:0];
                r_cib <= w_last_cib ? '0 : w_cib_inc[BLK_W-1:0];
            end
        end
    end

endmodule

// ===== rtl/bglyph_fifo.sv =====
// ----------------------------------------------------------------------------
// Block glyph job queue
// Short register queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module bglyph_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bglyph_pkg::t_job i_data,
    input  logic             i_pop,
    output bglyph_pkg::t_job o_head,
    output logic             o_full,
    output logic             o_empty
);
    import bglyph_pkg::*;

    localparam logic [QPTR_W-1:0] LastPtr = QPTR_W'(QUEUE_DEPTH - 1);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/bglyph_back.sv =====
// ----------------------------------------------------------------------------
// Block glyph back part
// Accumulates lightness per block column in memory, and for each completed
// block divides, scales to a glyph index and drives the output register.
// Also runs the memory clearing pass after reset.
// ----------------------------------------------------------------------------
module bglyph_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  bglyph_pkg::t_cfg        i_cfg,
    input  logic                    i_fifo_empty,
    input  bglyph_pkg::t_job        i_head,
    output logic                    o_pop,
    output logic                    o_clearing,
    output logic                    o_out_valid,
    output bglyph_pkg::t_glyph_item o_out_data,
    input  logic                    i_out_stall
);
    import bglyph_pkg::*;

    localparam logic [COL_W-1:0]       ClearLast = COL_W'(MAX_WIDTH - 1);
    localparam logic [IDX_RECIP_W-1:0] IdxRecip  = IDX_RECIP_W'(IDX_RECIP);
    localparam int                     ProdW     = SCALE_W + IDX_RECIP_W;

    t_back_state        r_state;
    t_back_state        n_state;
    t_job               r_job;
    logic [AVG_W-1:0]   r_avg;
    logic [SCALE_W-1:0] r_scale;
    logic [IDX_W-1:0]   r_idx;
    logic               r_out_valid;
    t_glyph_item        r_out_data;
    logic               r_clr_active;
    logic [COL_W-1:0]   r_clr_addr;

    logic               w_rd_en;
    logic               w_acc_wr;
    logic               w_ram_wr_en;
    logic [COL_W-1:0]   w_ram_wr_addr;
    logic [ENTRY_W-1:0] w_ram_wr_data;
    logic [ENTRY_W-1:0] w_rd_data;
    logic [SUM_W:0]     w_sum_ext;
    logic [CNT_W:0]     w_cnt_ext;
    logic [SUM_W-1:0]   w_new_sum;
    logic [CNT_W-1:0]   w_new_cnt;
    logic               w_out_free;
    logic               w_out_load;
    logic [ProdW-1:0]   w_idx_prod;
    logic [IDX_W-1:0]   w_idx_cl;
    logic [GWORD_W-1:0] w_word;
    logic [GLYPH_W-1:0] w_glyph;
    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;

    // Sum and count memory, one entry per block column.
    bglyph_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr_en),
        .i_wr_addr (w_ram_wr_addr),
        .i_wr_data (w_ram_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (i_head.slot),
        .o_rd_data (w_rd_data)
    );

    bglyph_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Saturating accumulate of the entry read for the current item.
    always_comb begin
        w_sum_ext = {1'b0, w_rd_data[ENTRY_W-1:CNT_W]} + (SUM_W+1)'(r_job.light);
        w_cnt_ext = {1'b0, w_rd_data[CNT_W-1:0]} + 1'b1;
        w_new_sum = w_sum_ext[SUM_W] ? '1 : w_sum_ext[SUM_W-1:0];
        w_new_cnt = w_cnt_ext[CNT_W] ? '1 : w_cnt_ext[CNT_W-1:0];
    end

    // Output register is free when empty or being taken this cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Sequencer: next state and control strobes.
    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        w_rd_en   = 1'b0;
        w_acc_wr  = 1'b0;
        w_out_load = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_new_sum;
        w_div_req.divisor  = w_new_cnt;
        case (r_state)
            BK_IDLE: begin
                if (!i_fifo_empty && !r_clr_active) begin
                    o_pop   = 1'b1;
                    w_rd_en = 1'b1;
                    n_state = BK_ACCUM;
                end
            end
            BK_ACCUM: begin
                w_acc_wr = 1'b1;
                if (r_job.emit) begin
                    w_div_req.start = 1'b1;
                    n_state = BK_DIVIDE;
                end else begin
                    n_state = BK_IDLE;
                end
            end
            BK_DIVIDE: begin
                if (w_div_rsp.done) begin
                    n_state = BK_SCALE;
                end
            end
            BK_SCALE: begin
                n_state = BK_INDEX;
            end
            BK_INDEX: begin
                n_state = BK_SEND;
            end
            BK_SEND: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Memory write: clearing pass first, then accumulate or clear on emit.
    always_comb begin
        if (r_clr_active) begin
            w_ram_wr_en   = 1'b1;
            w_ram_wr_addr = r_clr_addr;
            w_ram_wr_data = '0;
        end else begin
            w_ram_wr_en   = w_acc_wr;
            w_ram_wr_addr = r_job.slot;
            w_ram_wr_data = r_job.emit ? '0 : {w_new_sum, w_new_cnt};
        end
    end

    // Clearing pass over every entry after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ClearLast) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    assign o_clearing = r_clr_active;

    // Glyph index: len * avg / 255 via reciprocal, clamped to len - 1.
    assign w_idx_prod = ProdW'(r_scale) * ProdW'(IdxRecip);
    assign w_idx_cl   = (r_idx >= IDX_W'(i_cfg.len)) ? IDX_W'(i_cfg.len - 1'b1) : r_idx;

    // Pick the glyph byte out of the packed character words.
    always_comb begin
        case (w_idx_cl[IDX_W-1:3])
            2'd0:    w_word = i_cfg.glyphs[0];
            2'd1:    w_word = i_cfg.glyphs[1];
            2'd2:    w_word = i_cfg.glyphs[2];
            default: w_word = i_cfg.glyphs[0];
        endcase
        w_glyph = w_word[{w_idx_cl[2:0], 3'b000} +: GLYPH_W];
    end

    // Datapath registers along the sequence.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
        if (r_state == BK_DIVIDE && w_div_rsp.done) begin
            r_avg <= (|w_div_rsp.quotient[SUM_W-1:AVG_W]) ? '1
                                                          : w_div_rsp.quotient[AVG_W-1:0];
        end
        if (r_state == BK_SCALE) begin
            r_scale <= SCALE_W'(i_cfg.len) * SCALE_W'(r_avg);
        end
        if (r_state == BK_INDEX) begin
            r_idx <= w_idx_prod[IDX_SHIFT +: IDX_W];
        end
        if (w_out_load) begin
            r_out_data.glyph     <= w_glyph;
            r_out_data.row_end   <= r_job.row_end;
            r_out_data.image_end <= r_job.image_end;
        end
    end

    // Output item valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/block_average_to_ascii_glyph_top.sv =====
// ----------------------------------------------------------------------------
// Block average to ASCII glyph, top level
// A block-completing item is popped with a memory read, accumulated, divided
// by the 16-step divider for sum / count, scaled to a glyph index and loaded
// into the output register; an item that only accumulates is popped with a
// memory read, then written back. The back part finishes one item before it
// pops the next. Reset: synchronous; then a clearing pass zeroes the block
// memory, with the input stalled and configuration writes taken as usual.
// ----------------------------------------------------------------------------
module block_average_to_ascii_glyph_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  bglyph_pkg::t_pixel                 i_in_data,
    output logic                               o_in_stall,
    output logic                               o_out_valid,
    output bglyph_pkg::t_glyph_item            o_out_data,
    input  logic                               i_out_stall,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bglyph_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bglyph_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bglyph_pkg::APB_DATA_W-1:0]  prdata,
    output logic                               pready
);
    import bglyph_pkg::*;

    t_cfg w_cfg;
    t_job w_push_job;
    t_job w_head_job;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    logic w_clearing;

    // Register file.
    bglyph_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Pixel intake and classification.
    bglyph_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_cfg       (w_cfg),
        .i_fifo_full (w_full),
        .i_clearing  (w_clearing),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    // Queue between the two parts.
    bglyph_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .i_pop   (w_pop),
        .o_head  (w_head_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Accumulation, averaging and glyph output.
    bglyph_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_fifo_empty (w_empty),
        .i_head       (w_head_job),
        .o_pop        (w_pop),
        .o_clearing   (w_clearing),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

endmodule

// ===== rtl/bglyph_chk.sv =====
// ----------------------------------------------------------------------------
// Block glyph port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module bglyph_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input bglyph_pkg::t_glyph_item            o_out_data,
    input logic                               i_out_stall
);
    import bglyph_pkg::*;

    // The memory clearing pass must hold off input right after reset.
    a_stall_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> o_in_stall)
        else $error("input not stalled after reset");

    // No item may be offered straight out of reset.
    a_no_out_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_out_valid)
        else $error("output valid right after reset");

    // The last glyph of the image is also the last of its row.
    a_image_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.image_end) |-> o_out_data.row_end)
        else $error("image end without row end");

    // A stalled output item stays offered.
    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output item dropped while stalled");

    // A stalled output item keeps its payload.
    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

endmodule

bind block_average_to_ascii_glyph_top bglyph_chk u_bglyph_chk (.*);
